### hw/rtl/vnb_pkg.sv
// Shared types, widths and codes for the vertex normal blend core.
// No dependencies; every file but vnb_ram imports this package.
package vnb_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int IDX_W        = 10;
  localparam int COORD_W      = 16;
  localparam int ENTRY_W      = 6 * COORD_W;
  localparam int T_W          = 16;
  localparam int CNT_W        = 11;

  localparam logic signed [T_W-1:0] ONE_Q14 = 16'sd16384;
  localparam int Q14_SH   = 14;
  localparam int HALF_Q14 = 8192;
  localparam int NORM_SH  = 12;

  // Weight divider: quotient below one in Q1.14
  localparam int WDIV_STEPS = 14;

  // Normalize datapath widths
  localparam int M_W        = 19;
  localparam int SQ_W       = 36;
  localparam int S_W        = 38;
  localparam int ROOT_W     = S_W / 2;
  localparam int SQR_W      = ROOT_W + 2;
  localparam int SQ_STEPS   = ROOT_W;
  localparam int NDIV_STEPS = 14;
  localparam int N_W        = M_W - 1 + NORM_SH + 1;

  localparam int MQ_DEPTH = 4;
  localparam int MQ_PW    = $clog2(MQ_DEPTH);
  localparam int OQ_DEPTH = 2;
  localparam int OQ_PW    = $clog2(OQ_DEPTH);

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_MORPH  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] MODE_CLAMP = 2'd0;
  localparam logic [1:0] MODE_RAW   = 2'd1;
  localparam logic [1:0] MODE_INDEX = 2'd2;

  localparam logic CFG_WEIGHT_MODE  = 1'b0;
  localparam logic CFG_VERTEX_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]                op;
    logic [IDX_W-1:0]          vertex_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] norm_x;
    logic signed [COORD_W-1:0] norm_y;
    logic signed [COORD_W-1:0] norm_z;
    logic signed [T_W-1:0]     blend_weight;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]          out_index;
    logic signed [COORD_W-1:0] out_pos_x;
    logic signed [COORD_W-1:0] out_pos_y;
    logic signed [COORD_W-1:0] out_pos_z;
    logic signed [COORD_W-1:0] out_norm_x;
    logic signed [COORD_W-1:0] out_norm_y;
    logic signed [COORD_W-1:0] out_norm_z;
  } out_item_t;

  // Front to back: a load entry or a morph with its weight resolved
  typedef struct packed {
    logic [1:0]            op;
    logic [IDX_W-1:0]      idx;
    logic [ENTRY_W-1:0]    entry;
    logic signed [T_W-1:0] t;
  } mid_t;

endpackage

### hw/rtl/vnb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vnb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/vnb_front.sv
// Front end: input capture, configuration registers, weight selection and
// the pipelined index/(count-1) divider. Depends on vnb_pkg.
module vnb_front import vnb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  in_item_t         in_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CNT_W-1:0] cfg_data,
  output logic             mq_push,
  output mid_t             mq_item,
  input  logic             mq_full
);

  typedef struct packed {
    logic [1:0]            op;
    logic [IDX_W-1:0]      idx;
    logic [ENTRY_W-1:0]    entry;
    logic signed [T_W-1:0] t;
    logic                  use_div;
    logic [CNT_W-1:0]      d;
    logic [WDIV_STEPS-1:0] h;
    logic [CNT_W-1:0]      rem;
    logic [WDIV_STEPS-1:0] quo;
  } wtok_t;

  logic [1:0]       mode_r;
  logic [CNT_W-1:0] count_r;
  logic             vld_r [WDIV_STEPS+1];
  wtok_t            tok_r [WDIV_STEPS+1];
  logic             fadv;
  logic             accept;
  logic [CNT_W-1:0] dm1;
  wtok_t            prep;

  function automatic wtok_t wdiv_step(wtok_t s);
    wtok_t        o;
    logic [CNT_W:0] r2;
    logic         ge;
    o     = s;
    r2    = {s.rem, s.h[WDIV_STEPS-1]};
    ge    = r2 >= {1'b0, s.d};
    o.rem = ge ? CNT_W'(r2 - {1'b0, s.d}) : CNT_W'(r2);
    o.h   = s.h << 1;
    o.quo = {s.quo[WDIV_STEPS-2:0], ge};
    return o;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_CLAMP;
      count_r <= CNT_W'(MAX_VERTICES);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WEIGHT_MODE:  mode_r  <= cfg_data[1:0];
        CFG_VERTEX_COUNT: count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    dm1        = count_r - CNT_W'(1);
    prep       = '0;
    prep.op    = in_item.op;
    prep.idx   = in_item.vertex_index;
    prep.entry = {in_item.norm_z, in_item.norm_y, in_item.norm_x,
                  in_item.pos_z, in_item.pos_y, in_item.pos_x};
    prep.d     = dm1;
    // Rounding term (d/2) enters as the low dividend bits
    prep.h     = WDIV_STEPS'(dm1 >> 1);
    prep.rem   = CNT_W'(in_item.vertex_index);
    case (mode_r)
      MODE_RAW: begin
        prep.t = in_item.blend_weight;
      end
      MODE_INDEX: begin
        if (count_r < CNT_W'(2)) begin
          prep.t = '0;
        end else if (CNT_W'(in_item.vertex_index) >= dm1) begin
          prep.t = ONE_Q14;
        end else begin
          prep.use_div = 1'b1;
        end
      end
      default: begin
        if (in_item.blend_weight < 16'sd0) begin
          prep.t = '0;
        end else if (in_item.blend_weight > ONE_Q14) begin
          prep.t = ONE_Q14;
        end else begin
          prep.t = in_item.blend_weight;
        end
      end
    endcase
  end

  // Whole front stalls only when its last stage cannot drain
  assign fadv   = !(vld_r[WDIV_STEPS] && mq_full);
  assign full   = !fadv;
  assign accept = push && fadv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= WDIV_STEPS; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (fadv) begin
      vld_r[0] <= accept && (in_item.op != OP_NONE);
      for (int k = 1; k <= WDIV_STEPS; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fadv) begin
      tok_r[0] <= prep;
      for (int k = 1; k <= WDIV_STEPS; k++) begin
        tok_r[k] <= wdiv_step(tok_r[k-1]);
      end
    end
  end

  assign mq_push       = vld_r[WDIV_STEPS] && !mq_full;
  assign mq_item.op    = tok_r[WDIV_STEPS].op;
  assign mq_item.idx   = tok_r[WDIV_STEPS].idx;
  assign mq_item.entry = tok_r[WDIV_STEPS].entry;
  assign mq_item.t     = tok_r[WDIV_STEPS].use_div ?
                         $signed(T_W'(tok_r[WDIV_STEPS].quo)) : tok_r[WDIV_STEPS].t;

endmodule

### hw/rtl/vnb_queue.sv
// Short flop queue between the front and back ends.
// Depends on vnb_pkg for mid_t and depth.
module vnb_queue import vnb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_push,
  input  mid_t q_wr_item,
  output logic q_full,
  input  logic q_pop,
  output mid_t q_rd_item,
  output logic q_empty
);

  mid_t             q_r [MQ_DEPTH];
  logic [MQ_PW-1:0] wp_r;
  logic [MQ_PW-1:0] rp_r;
  logic [MQ_PW:0]   cnt_r;

  assign q_full    = cnt_r == (MQ_PW+1)'(MQ_DEPTH);
  assign q_empty   = cnt_r == '0;
  assign q_rd_item = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (q_push) begin
        wp_r <= wp_r + MQ_PW'(1);
      end
      if (q_pop) begin
        rp_r <= rp_r + MQ_PW'(1);
      end
      if (q_push && !q_pop) begin
        cnt_r <= cnt_r + (MQ_PW+1)'(1);
      end else if (q_pop && !q_push) begin
        cnt_r <= cnt_r - (MQ_PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_r[wp_r] <= q_wr_item;
    end
  end

endmodule

### hw/rtl/vnb_back.sv
// Back end: shape tables, blend multipliers, rounding, pipelined square
// root and divide for the normal, and the result queue. Uses vnb_pkg, vnb_ram.
module vnb_back import vnb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      mq_empty,
  input  mid_t      mq_item,
  output logic      mq_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  localparam int PA_W = T_W + 1 + COORD_W;
  localparam int PB_W = T_W + COORD_W;
  localparam int SUM_W = PA_W + 1;
  localparam logic signed [M_W-1:0] CMAX = M_W'((1 << (COORD_W-1)) - 1);
  localparam logic signed [M_W-1:0] CMIN = -CMAX - M_W'(1);

  typedef struct packed {
    logic [IDX_W-1:0]            idx;
    logic [2:0][COORD_W-1:0]     pos;
    logic [2:0][M_W-1:0]         m;
    logic [SQR_W-1:0]            rem;
    logic [ROOT_W-1:0]           root;
    logic [S_W-1:0]              sbits;
  } sqt_t;

  typedef struct packed {
    logic [IDX_W-1:0]            idx;
    logic [2:0][COORD_W-1:0]     pos;
    logic [2:0]                  neg;
    logic                        zero;
    logic [ROOT_W-1:0]           len;
    logic [2:0][ROOT_W-1:0]      rem;
    logic [2:0][NDIV_STEPS-1:0]  low;
    logic [2:0][NDIV_STEPS-1:0]  quo;
  } dvt_t;

  function automatic sqt_t sqrt_step(sqt_t s);
    sqt_t             o;
    logic [SQR_W+1:0] r2;
    logic [SQR_W+1:0] trial;
    logic             ge;
    o       = s;
    r2      = {s.rem, s.sbits[S_W-1 -: 2]};
    trial   = (SQR_W+2)'({s.root, 2'b01});
    ge      = r2 >= trial;
    o.rem   = ge ? SQR_W'(r2 - trial) : SQR_W'(r2);
    o.root  = {s.root[ROOT_W-2:0], ge};
    o.sbits = s.sbits << 2;
    return o;
  endfunction

  function automatic dvt_t div_step(dvt_t s);
    dvt_t            o;
    logic [ROOT_W:0] r2;
    logic            ge;
    o = s;
    for (int k = 0; k < 3; k++) begin
      r2       = {s.rem[k], s.low[k][NDIV_STEPS-1]};
      ge       = r2 >= {1'b0, s.len};
      o.rem[k] = ge ? ROOT_W'(r2 - {1'b0, s.len}) : ROOT_W'(r2);
      o.low[k] = s.low[k] << 1;
      o.quo[k] = {s.quo[k][NDIV_STEPS-2:0], ge};
    end
    return o;
  endfunction

  logic                       badv;
  logic                       fin_vld;
  logic [ENTRY_W-1:0]         a_dat;
  logic [ENTRY_W-1:0]         b_dat;
  logic [ADDR_W-1:0]          addr;
  logic                       we_a;
  logic                       we_b;
  logic                       rd_en;

  logic                       v1_r;
  logic [IDX_W-1:0]           idx1_r;
  logic signed [T_W-1:0]      t1_r;

  logic                       v2_r;
  logic [IDX_W-1:0]           idx2_r;
  logic signed [PA_W-1:0]     pa2_r [6];
  logic signed [PB_W-1:0]     pb2_r [6];

  logic                       v3_r;
  logic [IDX_W-1:0]           idx3_r;
  logic [2:0][COORD_W-1:0]    pos3_r;
  logic [2:0][M_W-1:0]        m3_r;

  logic                       v4_r;
  logic [IDX_W-1:0]           idx4_r;
  logic [2:0][COORD_W-1:0]    pos4_r;
  logic [2:0][M_W-1:0]        m4_r;
  logic [2:0][SQ_W-1:0]       sq4_r;

  logic                       v5_r;
  logic [IDX_W-1:0]           idx5_r;
  logic [2:0][COORD_W-1:0]    pos5_r;
  logic [2:0][M_W-1:0]        m5_r;
  logic [S_W-1:0]             sum5_r;

  logic                       sqv_r [SQ_STEPS];
  sqt_t                       sq_r  [SQ_STEPS];
  logic                       dvv_r [NDIV_STEPS+1];
  dvt_t                       dv_r  [NDIV_STEPS+1];

  logic signed [T_W:0]        w0;
  logic signed [PA_W-1:0]     pa [6];
  logic signed [PB_W-1:0]     pb [6];
  logic signed [SUM_W-1:0]    s;
  logic [SUM_W-1:0]           mag;
  logic [SUM_W-1:0]           rnd;
  logic signed [M_W-1:0]      mr;
  logic signed [M_W-1:0]      mv [6];
  logic signed [2*M_W-1:0]    prod [3];
  sqt_t                       sq_init;
  dvt_t                       dv_init;
  logic [M_W-1:0]             mabs;
  logic [N_W-1:0]             nval;

  out_item_t                  oq_r [OQ_DEPTH];
  logic [OQ_PW-1:0]           oq_wp_r;
  logic [OQ_PW-1:0]           oq_rp_r;
  logic [OQ_PW:0]             oq_cnt_r;
  logic                       oq_full;
  logic                       oq_push;
  logic                       oq_pop;
  out_item_t                  fin_item;
  logic [COORD_W-1:0]         nq [3];

  // ---------------- table access ----------------
  assign fin_vld = dvv_r[NDIV_STEPS];
  assign badv    = !(fin_vld && oq_full);
  assign mq_pop  = !mq_empty && badv;
  assign addr    = mq_item.idx[ADDR_W-1:0];
  assign we_a    = mq_pop && (mq_item.op == OP_LOAD_A);
  assign we_b    = mq_pop && (mq_item.op == OP_LOAD_B);
  assign rd_en   = mq_pop && (mq_item.op == OP_MORPH);

  vnb_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_VERTICES)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (addr),
    .wdata (mq_item.entry),
    .re    (rd_en),
    .raddr (addr),
    .rdata (a_dat)
  );

  vnb_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_VERTICES)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (addr),
    .wdata (mq_item.entry),
    .re    (rd_en),
    .raddr (addr),
    .rdata (b_dat)
  );

  // ---------------- datapath comb ----------------
  always_comb begin
    w0 = {1'b0, ONE_Q14} - {t1_r[T_W-1], t1_r};
    for (int k = 0; k < 6; k++) begin
      pa[k] = w0 * $signed(a_dat[k*COORD_W +: COORD_W]);
      pb[k] = t1_r * $signed(b_dat[k*COORD_W +: COORD_W]);
    end
  end

  // Round half away from zero after dropping the Q1.14 weight scale
  always_comb begin
    s   = '0;
    mag = '0;
    rnd = '0;
    mr  = '0;
    for (int k = 0; k < 6; k++) begin
      s     = SUM_W'(pa2_r[k]) + SUM_W'(pb2_r[k]);
      mag   = s[SUM_W-1] ? -s : s;
      rnd   = mag + SUM_W'(HALF_Q14);
      mr    = $signed(rnd[Q14_SH +: M_W]);
      mv[k] = s[SUM_W-1] ? -mr : mr;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = $signed(m3_r[k]) * $signed(m3_r[k]);
    end
  end

  always_comb begin
    sq_init       = '0;
    sq_init.idx   = idx5_r;
    sq_init.pos   = pos5_r;
    sq_init.m     = m5_r;
    sq_init.sbits = sum5_r;
  end

  always_comb begin
    dv_init      = '0;
    mabs         = '0;
    nval         = '0;
    dv_init.idx  = sq_r[SQ_STEPS-1].idx;
    dv_init.pos  = sq_r[SQ_STEPS-1].pos;
    dv_init.len  = sq_r[SQ_STEPS-1].root;
    dv_init.zero = sq_r[SQ_STEPS-1].root == '0;
    for (int k = 0; k < 3; k++) begin
      dv_init.neg[k] = sq_r[SQ_STEPS-1].m[k][M_W-1];
      mabs           = dv_init.neg[k] ? -sq_r[SQ_STEPS-1].m[k] : sq_r[SQ_STEPS-1].m[k];
      nval           = N_W'({mabs[M_W-2:0], NORM_SH'(0)}) +
                       N_W'(sq_r[SQ_STEPS-1].root >> 1);
      dv_init.rem[k] = ROOT_W'(nval >> NDIV_STEPS);
      dv_init.low[k] = nval[NDIV_STEPS-1:0];
    end
  end

  // ---------------- pipeline registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      for (int j = 0; j < SQ_STEPS; j++) begin
        sqv_r[j] <= 1'b0;
      end
      for (int j = 0; j <= NDIV_STEPS; j++) begin
        dvv_r[j] <= 1'b0;
      end
    end else if (badv) begin
      v1_r     <= rd_en;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      v4_r     <= v3_r;
      v5_r     <= v4_r;
      sqv_r[0] <= v5_r;
      for (int j = 1; j < SQ_STEPS; j++) begin
        sqv_r[j] <= sqv_r[j-1];
      end
      dvv_r[0] <= sqv_r[SQ_STEPS-1];
      for (int j = 1; j <= NDIV_STEPS; j++) begin
        dvv_r[j] <= dvv_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (badv) begin
      idx1_r <= mq_item.idx;
      t1_r   <= mq_item.t;

      idx2_r <= idx1_r;
      for (int k = 0; k < 6; k++) begin
        pa2_r[k] <= pa[k];
        pb2_r[k] <= pb[k];
      end

      idx3_r <= idx2_r;
      for (int k = 0; k < 3; k++) begin
        if (mv[k] > CMAX) begin
          pos3_r[k] <= COORD_W'(CMAX);
        end else if (mv[k] < CMIN) begin
          pos3_r[k] <= COORD_W'(CMIN);
        end else begin
          pos3_r[k] <= COORD_W'(mv[k]);
        end
        m3_r[k] <= mv[k+3];
      end

      idx4_r <= idx3_r;
      pos4_r <= pos3_r;
      m4_r   <= m3_r;
      for (int k = 0; k < 3; k++) begin
        sq4_r[k] <= prod[k][SQ_W-1:0];
      end

      idx5_r <= idx4_r;
      pos5_r <= pos4_r;
      m5_r   <= m4_r;
      sum5_r <= S_W'(sq4_r[0]) + S_W'(sq4_r[1]) + S_W'(sq4_r[2]);

      sq_r[0] <= sqrt_step(sq_init);
      for (int j = 1; j < SQ_STEPS; j++) begin
        sq_r[j] <= sqrt_step(sq_r[j-1]);
      end

      dv_r[0] <= dv_init;
      for (int j = 1; j <= NDIV_STEPS; j++) begin
        dv_r[j] <= div_step(dv_r[j-1]);
      end
    end
  end

  // ---------------- result assembly ----------------
  // |m| never exceeds the root, so the quotient stays within 4096
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nq[k] = COORD_W'(dv_r[NDIV_STEPS].quo[k]);
      if (dv_r[NDIV_STEPS].zero) begin
        nq[k] = '0;
      end else if (dv_r[NDIV_STEPS].neg[k]) begin
        nq[k] = -nq[k];
      end
    end
    fin_item.out_index  = dv_r[NDIV_STEPS].idx;
    fin_item.out_pos_x  = dv_r[NDIV_STEPS].pos[0];
    fin_item.out_pos_y  = dv_r[NDIV_STEPS].pos[1];
    fin_item.out_pos_z  = dv_r[NDIV_STEPS].pos[2];
    fin_item.out_norm_x = nq[0];
    fin_item.out_norm_y = nq[1];
    fin_item.out_norm_z = nq[2];
  end

  assign oq_full  = oq_cnt_r == (OQ_PW+1)'(OQ_DEPTH);
  assign empty    = oq_cnt_r == '0;
  assign oq_push  = fin_vld && !oq_full;
  assign oq_pop   = pop && !empty;
  assign out_item = oq_r[oq_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) begin
        oq_wp_r <= oq_wp_r + OQ_PW'(1);
      end
      if (oq_pop) begin
        oq_rp_r <= oq_rp_r + OQ_PW'(1);
      end
      if (oq_push && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + (OQ_PW+1)'(1);
      end else if (oq_pop && !oq_push) begin
        oq_cnt_r <= oq_cnt_r - (OQ_PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wp_r] <= fin_item;
    end
  end

endmodule

### hw/rtl/vertex_normal_blend_core.sv
// Top level of the vertex normal blend core: front end, middle queue, back end.
// Depends on vnb_pkg, vnb_front, vnb_queue, vnb_back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------
//   input    | push / full          | in_item  (in_item_t)
//   result   | empty / pop          | out_item (out_item_t)
//   config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per cycle sustained while no stall holds the front or back end; a
// morph result passes through 15 front stages incl. the weight divider, the
// middle queue, table read, blend, round, square, sum, 19 square root and 15
// divide stages, then the result queue.
// Loads write the shape tables in the back end, in order with morph reads.
// Synchronous active-low reset clears control only; table contents are
// undefined until loaded. Result backpressure stalls the back end; the front
// stalls once the four-entry middle queue is full and its last stage holds a beat.
module vertex_normal_blend_core import vnb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  in_item_t         in_item,
  input  logic             pop,
  output logic             empty,
  output out_item_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CNT_W-1:0] cfg_data
);

  logic mq_push;
  logic mq_full;
  logic mq_pop;
  logic mq_empty;
  mid_t mq_wr_item;
  mid_t mq_rd_item;

  vnb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mq_push   (mq_push),
    .mq_item   (mq_wr_item),
    .mq_full   (mq_full)
  );

  vnb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_push    (mq_push),
    .q_wr_item (mq_wr_item),
    .q_full    (mq_full),
    .q_pop     (mq_pop),
    .q_rd_item (mq_rd_item),
    .q_empty   (mq_empty)
  );

  vnb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .mq_empty (mq_empty),
    .mq_item  (mq_rd_item),
    .mq_pop   (mq_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

### hw/rtl/vnb_checker.sv
// Port-level checks for the vertex normal blend core, bound to the top level.
// Depends on vnb_pkg.
module vnb_checker import vnb_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             full,
  input logic             pop,
  input logic             empty,
  input out_item_t        out_item
);

  // Head result holds until popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("result changed before pop");

  a_reset_empty: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> empty)
    else $error("results present right after reset");

  a_reset_open: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> !full)
    else $error("input blocked right after reset");

  // A unit normal never exceeds one in any component
  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_item.out_norm_x <= 16'sd4096) && (out_item.out_norm_x >= -16'sd4096) &&
                (out_item.out_norm_y <= 16'sd4096) && (out_item.out_norm_y >= -16'sd4096) &&
                (out_item.out_norm_z <= 16'sd4096) && (out_item.out_norm_z >= -16'sd4096)))
    else $error("normal component out of unit range");

endmodule

bind vertex_normal_blend_core vnb_checker u_vnb_checker (.*);
